/* rtl/core/idf_pkg.sv */
// ----------------------------------------------------------------------------
// idf_pkg - shared types and codes for the ID acceptance filter
// Request and status codes, the link record passed along the cell chain, and
// the update command broadcast to the cells once a scan has finished.
// ----------------------------------------------------------------------------
package idf_pkg;

  localparam int ID_W             = 29;
  localparam int USERS_W          = 8;
  localparam int FILTER_SLOTS_DEF = 16;

  localparam logic [USERS_W-1:0] USERS_MAX = {USERS_W{1'b1}};

  // request codes
  localparam logic [1:0] REQ_ADD    = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_CHECK  = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // update applied to the marked cell after a scan
  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_INC   = 2'd1,
    CMD_DEC   = 2'd2,
    CMD_ALLOC = 2'd3
  } cmd_op_t;

  typedef struct packed {
    logic              valid;
    cmd_op_t           op;
    logic [ID_W-1:0]   id;
  } cmd_t;

  // scan record handed from cell to cell
  typedef struct packed {
    logic               active;
    logic [1:0]         req;
    logic [ID_W-1:0]    id;
    logic               hit;
    logic [USERS_W-1:0] users;
    logic               free_found;
  } link_t;

endpackage

/* rtl/core/idf_cell.sv */
// ----------------------------------------------------------------------------
// idf_cell - one filter slot of the chain
// Holds an ID, a valid bit and a user count. Compares the passing scan
// record, marks itself as the hit or the first free slot, and applies the
// broadcast update when it is the marked one.
// ----------------------------------------------------------------------------
module idf_cell import idf_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  link_t link_in,
  output link_t link_out,
  input  cmd_t  cmd
);

  logic [ID_W-1:0]    slot_id;
  logic               slot_valid;
  logic [USERS_W-1:0] slot_users;
  logic               mark_hit;
  logic               mark_free;
  logic               hit_here;
  logic               free_here;
  link_t              link_next;

  // local compare against the passing record
  assign hit_here  = slot_valid && (slot_id == link_in.id);
  assign free_here = !slot_valid && !link_in.free_found;

  always_comb begin
    link_next            = link_in;
    link_next.hit        = link_in.hit | hit_here;
    link_next.users      = hit_here ? slot_users : link_in.users;
    link_next.free_found = link_in.free_found | !slot_valid;
  end

  // chain register and marks
  always_ff @(posedge clk) begin
    if (rst) begin
      link_out  <= '0;
      mark_hit  <= 1'b0;
      mark_free <= 1'b0;
    end else begin
      link_out <= link_next;
      if (link_in.active) begin
        mark_hit  <= hit_here;
        mark_free <= free_here;
      end
    end
  end

  // slot update
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_users <= '0;
    end else if (cmd.valid) begin
      case (cmd.op)
        CMD_INC: begin
          if (mark_hit && slot_users != USERS_MAX) slot_users <= slot_users + 1'b1;
        end
        CMD_DEC: begin
          if (mark_hit) begin
            if (slot_users <= USERS_W'(1)) begin
              slot_users <= '0;
              slot_valid <= 1'b0;
            end else begin
              slot_users <= slot_users - 1'b1;
            end
          end
        end
        CMD_ALLOC: begin
          if (mark_free) begin
            slot_valid <= 1'b1;
            slot_users <= USERS_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // ID payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.op == CMD_ALLOC && mark_free) slot_id <= cmd.id;
  end

endmodule

/* rtl/core/refcounted_id_acceptance_filter_top.sv */
// ----------------------------------------------------------------------------
// refcounted_id_acceptance_filter_top - reference-counted ID filter pool
// A row of filter slots with add, remove and check requests.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_type and msg_id while busy is low; the item is taken
//   at that edge and busy rises until the result is shown.
//   One result per item appears on status, accepted and user_count with done
//   high for exactly one cycle; the receiver cannot hold it off.
//   The request record walks the slot chain, one cell a cycle, and the result
//   is registered from the chain's tail. The update to the hit or first free
//   slot is registered with the result and lands in the cycle after it. A new
//   item is taken only once busy falls, so items never overlap in the chain.
//   bypass is written through cfg_wr_en / cfg_wr_data; the user must write it
//   only while idle, as the block itself does not enforce this.
//   Synchronous reset empties every slot, clears bypass and idles the block.
// ----------------------------------------------------------------------------
module refcounted_id_acceptance_filter_top import idf_pkg::*; #(
  parameter int FILTER_SLOTS = FILTER_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type,
  input  logic [ID_W-1:0]    msg_id,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic               done,
  output logic [1:0]         status,
  output logic               accepted,
  output logic [USERS_W-1:0] user_count
);

  link_t              links [FILTER_SLOTS+1];
  link_t              head;
  link_t              tail;
  cmd_t               cmd;
  cmd_t               cmd_next;
  logic               pending;
  logic               bypass;
  logic               take;
  logic [1:0]         status_next;
  logic               accepted_next;
  logic [USERS_W-1:0] users_next;

  assign take  = start && !busy;
  assign busy  = pending;
  assign links[0] = head;
  assign tail  = links[FILTER_SLOTS];

  // cell chain
  for (genvar i = 0; i < FILTER_SLOTS; i++) begin : g_cell
    idf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .cmd      (cmd)
    );
  end

  // head of chain and item tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      pending <= 1'b0;
    end else begin
      head <= '{active: take, req: req_type, id: msg_id, hit: 1'b0,
                users: '0, free_found: 1'b0};
      if (take) pending <= 1'b1;
      else if (tail.active) pending <= 1'b0;
    end
  end

  // bypass register
  always_ff @(posedge clk) begin
    if (rst) bypass <= 1'b0;
    else if (cfg_wr_en) bypass <= cfg_wr_data;
  end

  // outcome from the finished scan
  always_comb begin
    status_next   = ST_OK;
    accepted_next = 1'b0;
    users_next    = '0;
    cmd_next      = '0;
    cmd_next.id   = tail.id;
    cmd_next.op   = CMD_NONE;
    case (tail.req)
      REQ_ADD: begin
        if (tail.hit) begin
          users_next  = (tail.users == USERS_MAX) ? USERS_MAX : tail.users + 1'b1;
          cmd_next.op = CMD_INC;
        end else if (tail.free_found) begin
          users_next  = USERS_W'(1);
          cmd_next.op = CMD_ALLOC;
        end else begin
          status_next = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (tail.hit) begin
          users_next  = (tail.users == '0) ? '0 : tail.users - 1'b1;
          cmd_next.op = CMD_DEC;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      REQ_CHECK: begin
        accepted_next = bypass | tail.hit;
        users_next    = tail.hit ? tail.users : '0;
      end
      default: ;
    endcase
    cmd_next.valid = tail.active && (cmd_next.op != CMD_NONE);
  end

  // result and update registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      cmd  <= '0;
    end else begin
      done <= tail.active;
      cmd  <= cmd_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tail.active) begin
      status     <= status_next;
      accepted   <= accepted_next;
      user_count <= users_next;
    end
  end

  // checks
  a_done_follows_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without an item in flight");

  a_tail_while_busy: assert property (@(posedge clk) disable iff (rst)
    tail.active |-> busy)
    else $error("scan finished with no item pending");

  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("block still busy when result shown");

  a_fail_no_count: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL || status == ST_NOT_FOUND)) |-> (user_count == '0 && !accepted))
    else $error("failed request reports a count");

  a_cmd_after_done: assert property (@(posedge clk) disable iff (rst)
    cmd.valid |-> done)
    else $error("slot update without a result");

endmodule

/* tb/refcounted_id_acceptance_filter_top_test.sv */
// ----------------------------------------------------------------------------
// refcounted_id_acceptance_filter_top_test - self-checking bench for the pool
// Drives add, remove and check items in random bursts, mirrors the slot table
// and bypass flag in an in-bench predictor, and compares every result field
// against the oldest outstanding prediction. Runs a directed opening, a run
// that saturates one count, then random phases with bypass toggled between.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module refcounted_id_acceptance_filter_top_test import idf_pkg::*;;

  localparam int SLOTS       = FILTER_SLOTS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = SLOTS + 4;

  // request code the block ignores
  localparam logic [1:0]      REQ_UNUSED = 2'd3;
  localparam logic [ID_W-1:0] ID_ALL     = '1;
  localparam logic [ID_W-1:0] ID_STD_MAX = 'h7FF;

  typedef struct packed {
    logic [1:0]      req;
    logic [ID_W-1:0] id;
  } filter_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               accepted;
    logic [USERS_W-1:0] users;
  } verdict_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         req_type = REQ_ADD;
  logic [ID_W-1:0]    msg_id = '0;
  logic               cfg_wr_en = 1'b0;
  logic               cfg_wr_data = 1'b0;
  logic               done;
  logic [1:0]         status;
  logic               accepted;
  logic [USERS_W-1:0] user_count;

  // mirror of the slot table and the bypass flag
  logic [ID_W-1:0]    tbl_id [SLOTS];
  logic               tbl_valid [SLOTS] = '{default: 1'b0};
  logic [USERS_W-1:0] tbl_users [SLOTS] = '{default: '0};
  logic               bypass_mirror = 1'b0;

  filter_req_t     pending_reqs[$];
  verdict_t        awaited_verdicts[$];
  logic [ID_W-1:0] id_pool[$];
  logic [ID_W-1:0] sat_id;
  int              errors = 0;
  int              burst_left = 0;
  int              gap_left = 0;
  int              stall_cycles = 0;

  refcounted_id_acceptance_filter_top #(
    .FILTER_SLOTS(SLOTS)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .msg_id     (msg_id),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .done       (done),
    .status     (status),
    .accepted   (accepted),
    .user_count (user_count)
  );

  always #2 clk = ~clk;

  // Apply one request to the mirrored table and return the expected result.
  function automatic verdict_t apply_request(filter_req_t r);
    verdict_t v;
    int       hit;
    int       free_slot;
    v.status   = ST_OK;
    v.accepted = 1'b0;
    v.users    = '0;
    hit        = -1;
    free_slot  = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_valid[i] && tbl_id[i] == r.id && hit < 0) hit = i;
      if (!tbl_valid[i] && free_slot < 0) free_slot = i;
    end
    case (r.req)
      REQ_ADD: begin
        if (hit >= 0) begin
          // count sticks at its maximum
          if (tbl_users[hit] != USERS_MAX) tbl_users[hit]++;
          v.users = tbl_users[hit];
        end else if (free_slot < 0) begin
          v.status = ST_FULL;
        end else begin
          tbl_id[free_slot]    = r.id;
          tbl_valid[free_slot] = 1'b1;
          tbl_users[free_slot] = USERS_W'(1);
          v.users              = USERS_W'(1);
        end
      end
      REQ_REMOVE: begin
        if (hit < 0) begin
          v.status = ST_NOT_FOUND;
        end else begin
          if (tbl_users[hit] != 0) tbl_users[hit]--;
          if (tbl_users[hit] == 0) tbl_valid[hit] = 1'b0;
          v.users = tbl_users[hit];
        end
      end
      REQ_CHECK: begin
        v.accepted = bypass_mirror || hit >= 0;
        if (hit >= 0) v.users = tbl_users[hit];
      end
      default: ;
    endcase
    return v;
  endfunction

  // Driver: bursts of items separated by random gaps
  always @(posedge clk) begin
    filter_req_t nxt;
    verdict_t    v;
    logic        took;
    if (rst) begin
      start      <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (cfg_wr_en) bypass_mirror = cfg_wr_data;
      took = start && !busy;
      if (took) begin
        v = apply_request('{req: req_type, id: msg_id});
        awaited_verdicts.push_back(v);
      end
      if (!start || took) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          nxt = pending_reqs.pop_front();
          start    <= 1'b1;
          req_type <= nxt.req;
          msg_id   <= nxt.id;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: each strobed result against the oldest prediction
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && done) begin
      if (awaited_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d accepted %0d users %0d",
                 $time, status, accepted, user_count);
        errors++;
      end else begin
        want = awaited_verdicts.pop_front();
        compare_field("status", want.status, status);
        compare_field("accepted", want.accepted, accepted);
        compare_field("user_count", want.users, user_count);
      end
    end
  end

  // Watchdog: too long with neither an item taken nor a result shown
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push_req(logic [1:0] req, logic [ID_W-1:0] id);
    pending_reqs.push_back('{req: req, id: id});
  endtask

  // Hold until everything sent has been answered
  task automatic wait_quiet();
    while (pending_reqs.size() != 0 || start || awaited_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // Let the last update land, then write bypass
  task automatic set_bypass(logic value);
    wait_quiet();
    repeat (SETTLE) @(negedge clk);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    @(negedge clk);
  endtask

  task automatic fill_id_pool(int n);
    logic [ID_W-1:0] v;
    id_pool.delete();
    id_pool.push_back('0);
    id_pool.push_back(ID_ALL);
    id_pool.push_back(sat_id);
    while (id_pool.size() < n) begin
      v = ID_W'($urandom);
      if ($urandom_range(0, 1) == 0) v = ID_W'($urandom_range(0, ID_STD_MAX));
      id_pool.push_back(v);
    end
  endtask

  // Mostly pool IDs with weighted ops; some noise IDs and unused requests
  task automatic queue_mix(int n, int add_w, int rem_w);
    int              roll;
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      id   = ID_W'($urandom);
      if (roll < 2) begin
        op = REQ_UNUSED;
      end else if (roll < 17) begin
        roll = $urandom_range(0, 2);
        op   = (roll == 0) ? REQ_ADD : (roll == 1) ? REQ_REMOVE : REQ_CHECK;
      end else begin
        id   = id_pool[$urandom_range(0, id_pool.size() - 1)];
        roll = $urandom_range(0, 99);
        op   = (roll < add_w) ? REQ_ADD : (roll < add_w + rem_w) ? REQ_REMOVE : REQ_CHECK;
      end
      push_req(op, id);
    end
  endtask

  initial begin
    sat_id = ID_W'($urandom);
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed opening, bypass off
    set_bypass(1'b0);
    push_req(REQ_CHECK, '0);
    push_req(REQ_REMOVE, '0);
    push_req(REQ_ADD, '0);
    push_req(REQ_ADD, ID_ALL);
    push_req(REQ_ADD, ID_STD_MAX);
    push_req(REQ_ADD, 'h0AAAAAAA);
    push_req(REQ_ADD, '0);
    push_req(REQ_CHECK, '0);
    push_req(REQ_CHECK, ID_ALL);
    push_req(REQ_REMOVE, ID_ALL);
    push_req(REQ_CHECK, ID_ALL);
    push_req(REQ_REMOVE, ID_ALL);
    push_req(REQ_ADD, 'h15555555);
    push_req(REQ_UNUSED, ID_ALL);
    push_req(REQ_REMOVE, '0);

    // bypass on: absent IDs still accepted, counts still reported
    set_bypass(1'b1);
    push_req(REQ_CHECK, 'h1234567);
    push_req(REQ_CHECK, '0);
    push_req(REQ_UNUSED, '0);
    push_req(REQ_ADD, ID_STD_MAX);
    push_req(REQ_REMOVE, ID_STD_MAX);
    push_req(REQ_CHECK, 'h15555555);

    // drive one count into saturation and back off it
    set_bypass(1'b0);
    for (int k = 0; k < 258; k++) begin
      push_req(REQ_ADD, sat_id);
      if (k % 32 == 31) push_req(REQ_CHECK, sat_id);
    end
    push_req(REQ_REMOVE, sat_id);
    push_req(REQ_ADD, sat_id);
    push_req(REQ_ADD, sat_id);
    push_req(REQ_CHECK, sat_id);

    // random phases: fill, drain and mixed traffic, bypass alternating
    set_bypass(1'b1);
    fill_id_pool(24);
    queue_mix(225, 45, 25);
    set_bypass(1'b0);
    fill_id_pool(24);
    queue_mix(225, 35, 35);
    set_bypass(1'b1);
    queue_mix(225, 25, 50);
    set_bypass(1'b0);
    fill_id_pool(20);
    queue_mix(225, 50, 20);
    set_bypass(1'b1);
    fill_id_pool(28);
    queue_mix(225, 35, 30);

    wait_quiet();
    repeat (SETTLE) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
